FILE: sv/hdr_autoexposure_gamma_tonemap_macros.svh
// Assertion macros for the tone mapper checker
`ifndef HDR_AUTOEXPOSURE_GAMMA_TONEMAP_MACROS_SVH
`define HDR_AUTOEXPOSURE_GAMMA_TONEMAP_MACROS_SVH

// same-cycle implication
`define HAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hag_pkg.sv
// Shared types, constants and root table of the HDR tone mapper
package hag_pkg;

	typedef struct packed {
		logic        func;
		logic [31:0] red_in;
		logic [31:0] green_in;
		logic [31:0] blue_in;
		logic        frame_end;
	} in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} out_t;

	typedef struct packed {
		logic [31:0] manual_exposure;
		logic [15:0] gamma_value;
		logic        auto_exposure_enable;
	} cfg_t;

	typedef enum logic [1:0] {
		CFG_MANUAL_EXPOSURE      = 2'd0,
		CFG_GAMMA_VALUE          = 2'd1,
		CFG_AUTO_EXPOSURE_ENABLE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_STAT,
		KIND_STAT_END,
		KIND_MAP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] red;
		logic [31:0] green;
		logic [31:0] blue;
	} qent_t;

	localparam logic [24:0] MAX_PIXELS       = 25'd16777216;
	localparam logic [31:0] RESET_EXPOSURE   = 32'd65536;
	localparam logic [15:0] RESET_GAMMA      = 16'd9011;
	localparam logic [15:0] LUM_WR           = 16'd19595;
	localparam logic [15:0] LUM_WG           = 16'd38470;
	localparam logic [15:0] LUM_WB           = 16'd7471;
	localparam logic [48:0] EPS_Q32          = 49'd429497;
	localparam logic signed [24:0] LN2_Q24   = 25'sd11629080;
	localparam logic signed [26:0] INVLN2_Q24 = 27'sd24204406;
	localparam logic signed [26:0] LN018_Q16 = -27'sd112381;

	typedef logic [19:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] a);
		logic [63:0] res;
		logic [63:0] bv;
		logic [63:0] rem;
		res = 64'd0;
		bv  = 64'h4000_0000_0000_0000;
		rem = a;
		for (int i = 0; i < 32; i++) begin
			if (bv > rem)
				bv = bv >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bv != 64'd0) begin
				if (rem >= res + bv) begin
					rem = rem - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		end
		return res;
	endfunction

	// Q1.30 roots 2^(2^-i), i = 1..20, each the floor sqrt of the one before
	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] r;
		r = 64'h8000_0000;
		for (int i = 0; i < 20; i++) begin
			r = isqrt64(r << 30);
			tab[i] = r[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t POW2_ROOTS = build_roots();

endpackage

FILE: sv/hag_front.sv
// Front end: accepts and classifies requests into a two-entry queue
module hag_front import hag_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  in_t   in_item,
	output logic  q_valid,
	input  logic  q_ready,
	output qent_t q_item
);

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	qent_t      ent_new;
	logic       push;
	logic       pop;

	always_comb begin
		ent_new.red   = in_item.red_in;
		ent_new.green = in_item.green_in;
		ent_new.blue  = in_item.blue_in;
		if (in_item.func)
			ent_new.kind = KIND_MAP;
		else if (in_item.frame_end)
			ent_new.kind = KIND_STAT_END;
		else
			ent_new.kind = KIND_STAT;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= ent_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: sv/hag_log2.sv
// Iterative log2: binary normalize, then one squaring per fraction bit
module hag_log2 import hag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        arg,
	output logic               done,
	output logic signed [25:0] result
);

	logic        busy_q;
	logic        sq_phase_q;
	logic [4:0]  step_q;
	logic [63:0] v_q;
	logic [5:0]  p_q;
	logic [30:0] m_q;
	logic [19:0] frac_q;
	logic        done_q;
	logic [5:0]  norm_amt;
	logic        norm_zero;
	logic [63:0] v_next;
	logic [61:0] sq;
	logic [31:0] m2;

	assign norm_amt  = 6'(6'd32 >> step_q[2:0]);
	assign norm_zero = ((v_q >> (7'd64 - {1'b0, norm_amt})) == 64'd0);
	assign v_next    = norm_zero ? (v_q << norm_amt) : v_q;
	assign sq        = {31'd0, m_q} * {31'd0, m_q};
	assign m2        = sq[61:30];

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= (arg == 64'd0) ? 64'd1 : arg;
			p_q    <= 6'd63;
			frac_q <= 20'd0;
		end else if (busy_q && !sq_phase_q) begin
			v_q <= v_next;
			m_q <= v_next[63:33];
			if (norm_zero)
				p_q <= p_q - norm_amt;
		end else if (busy_q) begin
			// mantissa in [2,4) after squaring: halve and emit a one
			if (m2[31]) begin
				m_q    <= m2[31:1];
				frac_q <= {frac_q[18:0], 1'b1};
			end else begin
				m_q    <= m2[30:0];
				frac_q <= {frac_q[18:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			sq_phase_q <= 1'b0;
			step_q     <= 5'd0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q     <= 1'b1;
				sq_phase_q <= 1'b0;
				step_q     <= 5'd0;
			end else if (busy_q && !sq_phase_q) begin
				if (step_q == 5'd5) begin
					sq_phase_q <= 1'b1;
					step_q     <= 5'd0;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end else if (busy_q) begin
				if (step_q == 5'd19) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	assign done   = done_q;
	// (p - 32) in six bits is p with its top bit flipped
	assign result = {~p_q[5], p_q[4:0], frac_q};

endmodule

FILE: sv/hag_div.sv
// Restoring divider, one quotient bit per cycle, 48 by 25 bits unsigned
module hag_div import hag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [24:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [24:0] rem_q;
	logic [47:0] quo_q;
	logic [24:0] b_q;
	logic        done_q;
	logic [25:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[47]};
	assign fits  = (trial >= {1'b0, b_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 25'd0;
			quo_q <= dividend;
			b_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 25'(trial - {1'b0, b_q}) : trial[24:0];
			quo_q <= {quo_q[46:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/hag_pow2.sv
// Iterative 2^y from Q.20: root products per fraction bit, then scale and saturate
module hag_pow2 import hag_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] y,
	input  logic               fb30,
	output logic               done,
	output logic [31:0]        result
);

	logic               busy_q;
	logic               shift_phase_q;
	logic [4:0]         step_q;
	logic signed [27:0] k_q;
	logic [19:0]        f_q;
	logic [31:0]        acc_q;
	logic               fb30_q;
	logic [31:0]        res_q;
	logic               done_q;
	logic [63:0]        prod;
	logic signed [29:0] s;
	logic [31:0]        cap;
	logic [63:0]        up;
	logic [5:0]         dn_amt;
	logic [31:0]        scaled;

	assign prod   = {32'd0, acc_q} * {32'd0, POW2_ROOTS[step_q]};
	assign s      = 30'(k_q) + (fb30_q ? 30'sd0 : -30'sd14);
	assign cap    = fb30_q ? 32'h4000_0000 : 32'hFFFF_FFFF;
	assign up     = {32'd0, acc_q} << s[5:0];
	assign dn_amt = 6'(-s);

	always_comb begin
		if (!s[29]) begin
			if (s >= 30'sd33)
				scaled = cap;
			else if (up > {32'd0, cap})
				scaled = cap;
			else
				scaled = up[31:0];
		end else if (s <= -30'sd63) begin
			scaled = 32'd0;
		end else begin
			scaled = acc_q >> dn_amt;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= 28'(y >>> 20);
			f_q    <= y[19:0];
			acc_q  <= 32'h4000_0000;
			fb30_q <= fb30;
		end else if (busy_q && !shift_phase_q) begin
			if (f_q[19])
				acc_q <= prod[61:30];
			f_q <= {f_q[18:0], 1'b0};
		end else if (busy_q) begin
			res_q <= scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			shift_phase_q <= 1'b0;
			step_q        <= 5'd0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q        <= 1'b1;
				shift_phase_q <= 1'b0;
				step_q        <= 5'd0;
			end else if (busy_q && !shift_phase_q) begin
				if (step_q == 5'd19)
					shift_phase_q <= 1'b1;
				else
					step_q <= step_q + 5'd1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: sv/hag_back.sv
// Back end: statistics accumulation, exposure update and per-channel mapping
module hag_back import hag_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	output logic  q_ready,
	input  qent_t q_item,
	output logic  out_valid,
	input  logic  out_ready,
	output out_t  out_item
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LUM, ST_SLOG, ST_ACC, ST_FEND, ST_SDIV, ST_TMUL, ST_SPOW,
		ST_MPROD, ST_MCLIP, ST_MLOG, ST_MDIV, ST_MPOW, ST_OUT
	} state_t;

	state_t             state_q;
	qent_t              item_q;
	logic [1:0]         idx_q;
	logic [48:0]        lum_q;
	logic signed [21:0] ln_q;
	logic signed [47:0] sum_q;
	logic [24:0]        tally_q;
	logic [31:0]        expo_q;
	logic [63:0]        prod_q;
	logic               neg_q;
	logic signed [25:0] mean_q;
	logic signed [47:0] y_q;
	logic               pow_fb30_q;
	logic [2:0][7:0]    bytes_q;
	out_t               out_q;
	logic               out_valid_q;
	logic               log_start_q;
	logic               div_start_q;
	logic               pow_start_q;
	logic [47:0]        div_a_q;
	logic [24:0]        div_b_q;

	logic [31:0]        chan;
	logic [15:0]        weight;
	logic [47:0]        lum_term;
	logic [31:0]        expo;
	logic [32:0]        prod_clip;
	logic [63:0]        log_arg;
	logic               log_done;
	logic signed [25:0] l2;
	logic [25:0]        l2_mag;
	logic signed [50:0] ln_prod;
	logic [47:0]        sum_mag;
	logic               div_done;
	logic [47:0]        div_q;
	logic signed [26:0] t_val;
	logic signed [52:0] tprod;
	logic               pow_done;
	logic [31:0]        pow_res;
	logic [39:0]        p255;
	logic [24:0]        gdiv;

	always_comb begin
		case (idx_q)
			2'd0:    begin chan = item_q.red;   weight = LUM_WR; end
			2'd1:    begin chan = item_q.green; weight = LUM_WG; end
			default: begin chan = item_q.blue;  weight = LUM_WB; end
		endcase
	end

	assign lum_term  = {16'd0, weight} * {16'd0, chan};
	assign expo      = cfg.auto_exposure_enable ? expo_q : cfg.manual_exposure;
	assign prod_clip = (prod_q > 64'h1_0000_0000) ? 33'h1_0000_0000 : prod_q[32:0];
	assign log_arg   = (item_q.kind == KIND_MAP) ? {31'd0, prod_clip} : {15'd0, lum_q};
	assign ln_prod   = l2 * LN2_Q24;
	assign l2_mag    = l2[25] ? 26'(-l2) : 26'(l2);
	assign sum_mag   = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
	assign t_val     = LN018_Q16 - 27'(mean_q);
	assign tprod     = t_val * INVLN2_Q24;
	assign p255      = {pow_res, 8'd0} - {8'd0, pow_res};
	assign gdiv      = (cfg.gamma_value == 16'd0) ? 25'd1 : {9'd0, cfg.gamma_value};

	hag_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start_q),
		.arg    (log_arg),
		.done   (log_done),
		.result (l2)
	);

	hag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	hag_pow2 u_pow2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pow_start_q),
		.y      (y_q),
		.fb30   (pow_fb30_q),
		.done   (pow_done),
		.result (pow_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= 48'sd0;
			tally_q     <= 25'd0;
			expo_q      <= RESET_EXPOSURE;
			out_valid_q <= 1'b0;
			log_start_q <= 1'b0;
			div_start_q <= 1'b0;
			pow_start_q <= 1'b0;
		end else begin
			log_start_q <= 1'b0;
			div_start_q <= 1'b0;
			pow_start_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (q_valid) begin
					item_q <= q_item;
					idx_q  <= 2'd0;
					lum_q  <= EPS_Q32;
					if (q_item.kind == KIND_MAP)
						state_q <= ST_MPROD;
					else if (cfg.auto_exposure_enable && tally_q < MAX_PIXELS)
						state_q <= ST_LUM;
					else
						state_q <= ST_FEND;
				end
				ST_LUM: begin
					lum_q <= lum_q + {1'b0, lum_term};
					if (idx_q == 2'd2) begin
						log_start_q <= 1'b1;
						state_q     <= ST_SLOG;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_SLOG: if (log_done) begin
					ln_q    <= 22'(ln_prod >>> 28);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= sum_q + 48'(ln_q);
					tally_q <= tally_q + 25'd1;
					state_q <= ST_FEND;
				end
				ST_FEND: begin
					if (item_q.kind == KIND_STAT_END) begin
						if (cfg.auto_exposure_enable && tally_q != 25'd0) begin
							div_a_q     <= sum_mag;
							div_b_q     <= tally_q;
							neg_q       <= sum_q[47];
							div_start_q <= 1'b1;
							state_q     <= ST_SDIV;
						end else begin
							sum_q   <= 48'sd0;
							tally_q <= 25'd0;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SDIV: if (div_done) begin
					mean_q  <= neg_q ? -26'(div_q) : 26'(div_q);
					state_q <= ST_TMUL;
				end
				ST_TMUL: begin
					y_q         <= 48'(tprod >>> 20);
					pow_fb30_q  <= 1'b0;
					pow_start_q <= 1'b1;
					state_q     <= ST_SPOW;
				end
				ST_SPOW: if (pow_done) begin
					expo_q  <= pow_res;
					sum_q   <= 48'sd0;
					tally_q <= 25'd0;
					state_q <= ST_IDLE;
				end
				ST_MPROD: begin
					prod_q  <= {32'd0, chan} * {32'd0, expo};
					state_q <= ST_MCLIP;
				end
				ST_MCLIP: begin
					if (prod_q == 64'd0) begin
						bytes_q[idx_q] <= 8'd0;
						if (idx_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_MPROD;
						end
					end else begin
						log_start_q <= 1'b1;
						state_q     <= ST_MLOG;
					end
				end
				ST_MLOG: if (log_done) begin
					neg_q       <= l2[25];
					div_a_q     <= {10'd0, l2_mag, 12'd0};
					div_b_q     <= gdiv;
					div_start_q <= 1'b1;
					state_q     <= ST_MDIV;
				end
				ST_MDIV: if (div_done) begin
					y_q         <= neg_q ? -$signed(div_q) : $signed(div_q);
					pow_fb30_q  <= 1'b1;
					pow_start_q <= 1'b1;
					state_q     <= ST_MPOW;
				end
				ST_MPOW: if (pow_done) begin
					bytes_q[idx_q] <= p255[37:30];
					if (idx_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_MPROD;
					end
				end
				ST_OUT: if (!out_valid_q || out_ready) begin
					out_q.red_out   <= bytes_q[0];
					out_q.green_out <= bytes_q[1];
					out_q.blue_out  <= bytes_q[2];
					out_valid_q     <= 1'b1;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign q_ready   = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: sv/hdr_autoexposure_gamma_tonemap.sv
// Top level of the log-average auto exposure and gamma tone mapper
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+---------------------------
//   in      | in  | in_valid / in_ready       | in_item  (in_t)
//   out     | out | out_valid / out_ready     | out_item (out_t)
//   cfg     | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Statistics pixel: intake, 3 luminance MACs, the log2 step, accumulate and frame
// check; only intake and frame check while auto is off or the tally is full.
// A frame-end pixel adds the divider step, 1 scale step and the pow2 step.
// Mapping pixel: each nonzero channel takes product, clip, log2, divider and pow2
// steps, a zero channel only product and clip; the divider dominates.
// Reset clears queue, sequencer, statistics and registers to their defaults.
// A two-entry queue takes requests while the back end works; a full
// output register holds the back end in its output state.
module hdr_autoexposure_gamma_tonemap import hag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_ready;
	qent_t q_item;

	// configuration is always taken; writes to index 3 are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manual_exposure      <= RESET_EXPOSURE;
			cfg_q.gamma_value          <= RESET_GAMMA;
			cfg_q.auto_exposure_enable <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MANUAL_EXPOSURE:      cfg_q.manual_exposure      <= cfg_data;
				CFG_GAMMA_VALUE:          cfg_q.gamma_value          <= cfg_data[15:0];
				CFG_AUTO_EXPOSURE_ENABLE: cfg_q.auto_exposure_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: request intake and classification
	hag_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// back: sequencer with shared log2, divider and pow2 units
	hag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: sv/hag_checker.sv
// Port-level checker for the tone mapper, bound to the top level
`include "hdr_autoexposure_gamma_tonemap_macros.svh"

module hag_checker import hag_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input out_t        out_item,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`HAG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")
	`HAG_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write not taken")
	`HAG_ASSERT_NOW(a_full_cause, $fell(in_ready), $past(in_valid && in_ready), "queue filled without a request")

endmodule

bind hdr_autoexposure_gamma_tonemap hag_checker u_chk (.*);
